### src/rgbpfc_pkg.sv
`timescale 1ns / 1ps

package rgbpfc_pkg;

  // Default geometry
  localparam int unsigned CHANNEL_BITS = 8;
  localparam int unsigned PIXEL_BITS   = 32;

  // Fixed field widths
  localparam int unsigned PIXEL_W   = 32;
  localparam int unsigned SHIFT_W   = 5;
  localparam int unsigned SHIFTS_W  = 3 * SHIFT_W;
  localparam int unsigned SIZE_W    = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_CH    = 3;

  localparam logic [SHIFTS_W-1:0] SHIFTS_RESET = 15'd16640;

  // Pixel size codes
  localparam logic [SIZE_W-1:0] SIZE_1B = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_2B = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_4B = 2'd2;

  // Register map
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_MAXES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_SHIFTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_MAXES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_SHIFTS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_SIZE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_SIZE   = 3'd5;

  // Shift and size settings used by the extract and pack stages
  typedef struct packed {
    logic [SHIFTS_W-1:0] src_shifts;
    logic [SHIFTS_W-1:0] dst_shifts;
    logic [SIZE_W-1:0]   src_size;
    logic [SIZE_W-1:0]   dst_size;
  } cfg_ctl_t;

  // Mask of the bits a pixel of the given size code occupies
  function automatic logic [PIXEL_W-1:0] size_mask(input logic [SIZE_W-1:0] code,
                                                   input int unsigned pixel_bits);
    logic [PIXEL_W-1:0] mask;
    case (code)
      SIZE_1B: mask = {{(PIXEL_W-8){1'b0}}, {8{1'b1}}};
      SIZE_2B: mask = {{(PIXEL_W-16){1'b0}}, {16{1'b1}}};
      default: mask = {PIXEL_W{1'b1}} >> (PIXEL_W - pixel_bits);
    endcase
    return mask;
  endfunction

  // Five-bit shift of one channel: 0 blue, 1 green, 2 red
  function automatic logic [SHIFT_W-1:0] shift_field(input logic [SHIFTS_W-1:0] shifts,
                                                     input int unsigned ch);
    return shifts[ch*SHIFT_W +: SHIFT_W];
  endfunction

endpackage

### src/rgbpfc_cfg_regs.sv
`timescale 1ns / 1ps

module rgbpfc_cfg_regs #(
  parameter int unsigned ChannelBits = rgbpfc_pkg::CHANNEL_BITS,
  parameter int unsigned CfgDataW    = 3 * ChannelBits
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rgbpfc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]                  cfg_data_i,
  output logic [3*ChannelBits-1:0]             src_maxes_o,
  output logic [3*ChannelBits-1:0]             dst_maxes_o,
  output rgbpfc_pkg::cfg_ctl_t                 ctl_o
);

  localparam int unsigned MaxesW = 3 * ChannelBits;

  logic [MaxesW-1:0]    src_maxes_q;
  logic [MaxesW-1:0]    dst_maxes_q;
  rgbpfc_pkg::cfg_ctl_t ctl_q;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_maxes_q      <= {MaxesW{1'b1}};
      dst_maxes_q      <= {MaxesW{1'b1}};
      ctl_q.src_shifts <= rgbpfc_pkg::SHIFTS_RESET;
      ctl_q.dst_shifts <= rgbpfc_pkg::SHIFTS_RESET;
      ctl_q.src_size   <= rgbpfc_pkg::SIZE_4B;
      ctl_q.dst_size   <= rgbpfc_pkg::SIZE_4B;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        rgbpfc_pkg::CFG_SRC_MAXES:  src_maxes_q      <= cfg_data_i[MaxesW-1:0];
        rgbpfc_pkg::CFG_SRC_SHIFTS: ctl_q.src_shifts <= cfg_data_i[rgbpfc_pkg::SHIFTS_W-1:0];
        rgbpfc_pkg::CFG_DST_MAXES:  dst_maxes_q      <= cfg_data_i[MaxesW-1:0];
        rgbpfc_pkg::CFG_DST_SHIFTS: ctl_q.dst_shifts <= cfg_data_i[rgbpfc_pkg::SHIFTS_W-1:0];
        rgbpfc_pkg::CFG_SRC_SIZE:   ctl_q.src_size   <= cfg_data_i[rgbpfc_pkg::SIZE_W-1:0];
        rgbpfc_pkg::CFG_DST_SIZE:   ctl_q.dst_size   <= cfg_data_i[rgbpfc_pkg::SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign src_maxes_o = src_maxes_q;
  assign dst_maxes_o = dst_maxes_q;
  assign ctl_o       = ctl_q;

endmodule

### src/rgbpfc_front.sv
`timescale 1ns / 1ps

module rgbpfc_front #(
  parameter int unsigned ChannelBits = rgbpfc_pkg::CHANNEL_BITS,
  parameter int unsigned PixelBits   = rgbpfc_pkg::PIXEL_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic [rgbpfc_pkg::PIXEL_W-1:0]        pixel_i,
  input  rgbpfc_pkg::cfg_ctl_t                  ctl_i,
  input  logic [3*ChannelBits-1:0]              src_maxes_i,
  input  logic [3*ChannelBits-1:0]              dst_maxes_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic [2:0][2*ChannelBits-1:0]         dividend_o
);

  localparam int unsigned DivW = 2 * ChannelBits;

  logic [rgbpfc_pkg::PIXEL_W-1:0] pix_masked;
  logic [rgbpfc_pkg::PIXEL_W-1:0] pix_shifted [3];
  logic                           round_en;
  logic [2:0][ChannelBits-1:0]    smax;
  logic [2:0][ChannelBits-1:0]    dmax;
  logic [2:0][ChannelBits-1:0]    value;
  logic [2:0][DivW-1:0]           bias;
  logic [2:0][DivW-1:0]           dividend_d;
  logic [2:0][DivW-1:0]           dividend_q;
  logic                           valid_q;

  // Extract each channel, scale by the target max, add the rounding bias
  always_comb begin
    pix_masked = pixel_i & rgbpfc_pkg::size_mask(ctl_i.src_size, PixelBits);
    round_en   = (ctl_i.src_size >= rgbpfc_pkg::SIZE_4B);
    for (int unsigned ch = 0; ch < rgbpfc_pkg::NUM_CH; ch++) begin
      smax[ch]        = src_maxes_i[ch*ChannelBits +: ChannelBits];
      dmax[ch]        = dst_maxes_i[ch*ChannelBits +: ChannelBits];
      pix_shifted[ch] = pix_masked >> rgbpfc_pkg::shift_field(ctl_i.src_shifts, ch);
      value[ch]       = pix_shifted[ch][ChannelBits-1:0] & smax[ch];
      bias[ch]        = round_en ? DivW'(smax[ch] >> 1) : '0;
      // value <= smax, so the sum stays below smax * 2^ChannelBits
      dividend_d[ch]  = (DivW'(value[ch]) * DivW'(dmax[ch])) + bias[ch];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dividend_q <= dividend_d;
    end
  end

  assign valid_o    = valid_q;
  assign dividend_o = dividend_q;

endmodule

### src/rgbpfc_div_step.sv
`timescale 1ns / 1ps

module rgbpfc_div_step #(
  parameter int unsigned ChannelBits = rgbpfc_pkg::CHANNEL_BITS,
  parameter int unsigned Step        = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [2:0][2*ChannelBits-1:0] rem_i,
  input  logic [2:0][ChannelBits-1:0]   quo_i,
  input  logic [3*ChannelBits-1:0]      src_maxes_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [2:0][2*ChannelBits-1:0] rem_o,
  output logic [2:0][ChannelBits-1:0]   quo_o
);

  localparam int unsigned DivW = 2 * ChannelBits;

  logic [2:0][DivW-1:0]        trial;
  logic [2:0][DivW-1:0]        rem_d;
  logic [2:0][ChannelBits-1:0] quo_d;
  logic [2:0][DivW-1:0]        rem_q;
  logic [2:0][ChannelBits-1:0] quo_q;
  logic                        valid_q;

  // One restoring step: quotient bit Step of every channel
  always_comb begin
    for (int unsigned ch = 0; ch < rgbpfc_pkg::NUM_CH; ch++) begin
      trial[ch] = DivW'(src_maxes_i[ch*ChannelBits +: ChannelBits]) << Step;
      if (rem_i[ch] >= trial[ch]) begin
        rem_d[ch] = rem_i[ch] - trial[ch];
        quo_d[ch] = quo_i[ch] | (ChannelBits'(1) << Step);
      end else begin
        rem_d[ch] = rem_i[ch];
        quo_d[ch] = quo_i[ch];
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;

endmodule

### src/rgbpfc_pack.sv
`timescale 1ns / 1ps

module rgbpfc_pack #(
  parameter int unsigned ChannelBits = rgbpfc_pkg::CHANNEL_BITS,
  parameter int unsigned PixelBits   = rgbpfc_pkg::PIXEL_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [2:0][ChannelBits-1:0]    quo_i,
  input  rgbpfc_pkg::cfg_ctl_t           ctl_i,
  input  logic [3*ChannelBits-1:0]       src_maxes_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [rgbpfc_pkg::PIXEL_W-1:0] pixel_o
);

  logic [ChannelBits-1:0]         chan [3];
  logic [rgbpfc_pkg::PIXEL_W-1:0] pixel_d;
  logic [rgbpfc_pkg::PIXEL_W-1:0] pixel_q;
  logic                           valid_q;

  // Place each channel, merge, trim to the target width
  always_comb begin
    pixel_d = '0;
    for (int unsigned ch = 0; ch < rgbpfc_pkg::NUM_CH; ch++) begin
      // zero source max: channel contributes nothing
      chan[ch] = (src_maxes_i[ch*ChannelBits +: ChannelBits] == '0) ? '0 : quo_i[ch];
      pixel_d  = pixel_d | (rgbpfc_pkg::PIXEL_W'(chan[ch])
                            << rgbpfc_pkg::shift_field(ctl_i.dst_shifts, ch));
    end
    pixel_d = pixel_d & rgbpfc_pkg::size_mask(ctl_i.dst_size, PixelBits);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pixel_q <= pixel_d;
    end
  end

  assign valid_o = valid_q;
  assign pixel_o = pixel_q;

endmodule

### src/rgb_pixel_format_converter.sv
`timescale 1ns / 1ps

// RGB pixel format converter. Takes one packed pixel per clock while the
// input is not stalled and returns it re-packed in the target format: each
// channel is pulled out at its source shift and max, rescaled to
// value*dst_max/src_max (rounded for 4-byte sources, truncated otherwise),
// moved to its target shift, and the merged word is trimmed to the target
// size. A zero source max yields zero for that channel. The pipe has one
// stage for extract and multiply, one restoring divide stage per quotient
// bit and one stage for packing. Each stage holds its beat under stall and
// bubbles close up, so the input keeps flowing until every stage is full.
// Write the registers only while no pixel is in flight.
module rgb_pixel_format_converter #(
  parameter int unsigned ChannelBits = rgbpfc_pkg::CHANNEL_BITS,
  parameter int unsigned PixelBits   = rgbpfc_pkg::PIXEL_BITS,
  parameter int unsigned CfgDataW    = (3 * ChannelBits > rgbpfc_pkg::SHIFTS_W) ?
                                       3 * ChannelBits : rgbpfc_pkg::SHIFTS_W
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // source pixels
  input  logic                              src_valid_i,
  output logic                              src_stall_o,
  input  logic [rgbpfc_pkg::PIXEL_W-1:0]    source_pixel_i,
  // converted pixels
  output logic                              dst_valid_o,
  input  logic                              dst_stall_i,
  output logic [rgbpfc_pkg::PIXEL_W-1:0]    target_pixel_o,
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rgbpfc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0]               cfg_data_i
);

  localparam int unsigned DivW = 2 * ChannelBits;

  logic [3*ChannelBits-1:0]                    src_maxes;
  logic [3*ChannelBits-1:0]                    dst_maxes;
  rgbpfc_pkg::cfg_ctl_t                        ctl;
  logic                                        front_ready;
  logic [ChannelBits:0]                        dv_valid;
  logic [ChannelBits:0]                        dv_ready;
  logic [ChannelBits:0][2:0][DivW-1:0]         dv_rem;
  logic [ChannelBits:0][2:0][ChannelBits-1:0]  dv_quo;

  rgbpfc_cfg_regs #(
    .ChannelBits (ChannelBits),
    .CfgDataW    (CfgDataW)
  ) u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .src_maxes_o (src_maxes),
    .dst_maxes_o (dst_maxes),
    .ctl_o       (ctl)
  );

  assign src_stall_o = !front_ready;

  // Extract, multiply, bias
  rgbpfc_front #(
    .ChannelBits (ChannelBits),
    .PixelBits   (PixelBits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (src_valid_i),
    .ready_o     (front_ready),
    .pixel_i     (source_pixel_i),
    .ctl_i       (ctl),
    .src_maxes_i (src_maxes),
    .dst_maxes_i (dst_maxes),
    .valid_o     (dv_valid[0]),
    .ready_i     (dv_ready[0]),
    .dividend_o  (dv_rem[0])
  );

  assign dv_quo[0] = '0;

  // Restoring divider, most significant quotient bit first
  for (genvar k = 0; k < ChannelBits; k++) begin : g_div
    rgbpfc_div_step #(
      .ChannelBits (ChannelBits),
      .Step        (ChannelBits - 1 - k)
    ) u_div_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .valid_i     (dv_valid[k]),
      .ready_o     (dv_ready[k]),
      .rem_i       (dv_rem[k]),
      .quo_i       (dv_quo[k]),
      .src_maxes_i (src_maxes),
      .valid_o     (dv_valid[k+1]),
      .ready_i     (dv_ready[k+1]),
      .rem_o       (dv_rem[k+1]),
      .quo_o       (dv_quo[k+1])
    );
  end

  // Place channels and drive the output register
  rgbpfc_pack #(
    .ChannelBits (ChannelBits),
    .PixelBits   (PixelBits)
  ) u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (dv_valid[ChannelBits]),
    .ready_o     (dv_ready[ChannelBits]),
    .quo_i       (dv_quo[ChannelBits]),
    .ctl_i       (ctl),
    .src_maxes_i (src_maxes),
    .valid_o     (dst_valid_o),
    .ready_i     (!dst_stall_i),
    .pixel_o     (target_pixel_o)
  );

endmodule

### src/rgbpfc_checker.sv
`timescale 1ns / 1ps

module rgbpfc_checker #(
  parameter int unsigned PixelBits = rgbpfc_pkg::PIXEL_BITS
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           src_stall_o,
  input logic                           dst_valid_o,
  input logic                           dst_stall_i,
  input logic [rgbpfc_pkg::PIXEL_W-1:0] target_pixel_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o
);

  // A stalled output beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dst_valid_o && dst_stall_i |=> dst_valid_o && $stable(target_pixel_o))
    else $error("output beat changed under stall");

  // Input backs up only when the whole pipe is full behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    src_stall_o |-> dst_valid_o && dst_stall_i)
    else $error("input stalled while the pipe has room");

  // Nothing appears above the widest pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dst_valid_o |-> (target_pixel_o >> PixelBits) == '0)
    else $error("output bits set above pixel width");

  // Register writes never wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("register write held off");

endmodule

bind rgb_pixel_format_converter rgbpfc_checker #(
  .PixelBits (PixelBits)
) u_rgbpfc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .src_stall_o    (src_stall_o),
  .dst_valid_o    (dst_valid_o),
  .dst_stall_i    (dst_stall_i),
  .target_pixel_o (target_pixel_o),
  .cfg_valid_i    (cfg_valid_i),
  .cfg_ready_o    (cfg_ready_o)
);

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CB           = rgbpfc_pkg::CHANNEL_BITS;
  localparam int unsigned CFG_DATA_W   = 3 * CB;
  localparam int unsigned LATENCY      = CB + 2;
  localparam int unsigned RAND_PHASES  = 11;
  localparam int unsigned PHASE_PIXELS = 105;
  localparam int unsigned HOLD_CYCLES  = 80;

  // Indexes past the register map; writes there must change nothing
  localparam logic [rgbpfc_pkg::CFG_IDX_W-1:0] CFG_NONE_A = 3'd6;
  localparam logic [rgbpfc_pkg::CFG_IDX_W-1:0] CFG_NONE_B = 3'd7;
  // Size code outside the documented set, behaves as the widest size
  localparam logic [rgbpfc_pkg::SIZE_W-1:0] SIZE_SPARE = 2'd3;

  // Common pixel formats used for realistic conversions
  localparam int unsigned FMT_RGB888 = 0;
  localparam int unsigned FMT_BGR888 = 1;
  localparam int unsigned FMT_RGB565 = 2;
  localparam int unsigned FMT_RGB555 = 3;
  localparam int unsigned FMT_RGB444 = 4;
  localparam int unsigned FMT_RGB332 = 5;
  localparam int unsigned FMT_RGBX   = 6;
  localparam int unsigned FMT_COUNT  = 7;

  typedef struct packed {
    logic [CFG_DATA_W-1:0]           maxes;
    logic [rgbpfc_pkg::SHIFTS_W-1:0] shifts;
    logic [rgbpfc_pkg::SIZE_W-1:0]   size;
  } fmt_t;

  typedef struct packed {
    logic [rgbpfc_pkg::PIXEL_W-1:0] source;
    logic [rgbpfc_pkg::PIXEL_W-1:0] target;
  } conv_beat_t;

  logic                              clk_i          = 1'b0;
  logic                              rst_ni         = 1'b0;
  logic                              src_valid_i    = 1'b0;
  logic                              src_stall_o;
  logic [rgbpfc_pkg::PIXEL_W-1:0]    source_pixel_i = '0;
  logic                              dst_valid_o;
  logic                              dst_stall_i    = 1'b0;
  logic [rgbpfc_pkg::PIXEL_W-1:0]    target_pixel_o;
  logic                              cfg_valid_i    = 1'b0;
  logic                              cfg_ready_o;
  logic [rgbpfc_pkg::CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0]             cfg_data_i     = '0;

  // Shadow copy of the register file
  logic [CFG_DATA_W-1:0]           src_max_r   = '1;
  logic [rgbpfc_pkg::SHIFTS_W-1:0] src_shift_r = rgbpfc_pkg::SHIFTS_RESET;
  logic [CFG_DATA_W-1:0]           dst_max_r   = '1;
  logic [rgbpfc_pkg::SHIFTS_W-1:0] dst_shift_r = rgbpfc_pkg::SHIFTS_RESET;
  logic [rgbpfc_pkg::SIZE_W-1:0]   src_size_r  = rgbpfc_pkg::SIZE_4B;
  logic [rgbpfc_pkg::SIZE_W-1:0]   dst_size_r  = rgbpfc_pkg::SIZE_4B;

  logic [rgbpfc_pkg::PIXEL_W-1:0] source_fifo[$];
  conv_beat_t                     converted_fifo[$];
  conv_beat_t                     head_beat;

  int unsigned src_gap      = 0;
  int unsigned dst_gap      = 0;
  int unsigned err_count    = 0;
  logic        quiet        = 1'b0;
  logic        hold_go      = 1'b0;
  logic        long_hold_on = 1'b0;

  rgb_pixel_format_converter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .src_valid_i    (src_valid_i),
    .src_stall_o    (src_stall_o),
    .source_pixel_i (source_pixel_i),
    .dst_valid_o    (dst_valid_o),
    .dst_stall_i    (dst_stall_i),
    .target_pixel_o (target_pixel_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Bits a pixel of the given size code occupies
  function automatic logic [rgbpfc_pkg::PIXEL_W-1:0] width_mask(
      input logic [rgbpfc_pkg::SIZE_W-1:0] code);
    case (code)
      rgbpfc_pkg::SIZE_1B: return 32'h0000_00FF;
      rgbpfc_pkg::SIZE_2B: return 32'h0000_FFFF;
      default:             return '1;
    endcase
  endfunction

  // Expected converted pixel under the current shadow registers
  function automatic logic [rgbpfc_pkg::PIXEL_W-1:0] convert_pixel(
      input logic [rgbpfc_pkg::PIXEL_W-1:0] pix);
    logic [63:0]                    src_word;
    logic [63:0]                    value;
    logic [63:0]                    scaled;
    logic [63:0]                    merged;
    logic [CB-1:0]                  smax;
    logic [CB-1:0]                  dmax;
    logic [rgbpfc_pkg::SHIFT_W-1:0] ssh;
    logic [rgbpfc_pkg::SHIFT_W-1:0] dsh;
    src_word = 64'(pix & width_mask(src_size_r));
    merged   = '0;
    for (int ch = 0; ch < rgbpfc_pkg::NUM_CH; ch++) begin
      smax = src_max_r[ch*CB +: CB];
      dmax = dst_max_r[ch*CB +: CB];
      ssh  = src_shift_r[ch*rgbpfc_pkg::SHIFT_W +: rgbpfc_pkg::SHIFT_W];
      dsh  = dst_shift_r[ch*rgbpfc_pkg::SHIFT_W +: rgbpfc_pkg::SHIFT_W];
      // zero source max: channel drops out
      if (smax != '0) begin
        value  = (src_word >> ssh) & 64'(smax);
        scaled = value * 64'(dmax);
        // only 1- and 2-byte sources truncate
        if (src_size_r != rgbpfc_pkg::SIZE_1B && src_size_r != rgbpfc_pkg::SIZE_2B)
          scaled += 64'(smax >> 1);
        scaled = scaled / 64'(smax);
        merged |= scaled << dsh;
      end
    end
    return rgbpfc_pkg::PIXEL_W'(merged & 64'(width_mask(dst_size_r)));
  endfunction

  function automatic logic [rgbpfc_pkg::SHIFTS_W-1:0] pack_shifts(input int unsigned r,
                                                                  input int unsigned g,
                                                                  input int unsigned b);
    return {rgbpfc_pkg::SHIFT_W'(r), rgbpfc_pkg::SHIFT_W'(g), rgbpfc_pkg::SHIFT_W'(b)};
  endfunction

  function automatic fmt_t common_format(input int unsigned sel);
    case (sel)
      FMT_RGB888: return '{24'hFF_FF_FF, pack_shifts(16, 8, 0), rgbpfc_pkg::SIZE_4B};
      FMT_BGR888: return '{24'hFF_FF_FF, pack_shifts(0, 8, 16), rgbpfc_pkg::SIZE_4B};
      FMT_RGB565: return '{24'h1F_3F_1F, pack_shifts(11, 5, 0), rgbpfc_pkg::SIZE_2B};
      FMT_RGB555: return '{24'h1F_1F_1F, pack_shifts(10, 5, 0), rgbpfc_pkg::SIZE_2B};
      FMT_RGB444: return '{24'h0F_0F_0F, pack_shifts(8, 4, 0), rgbpfc_pkg::SIZE_2B};
      FMT_RGB332: return '{24'h07_07_03, pack_shifts(5, 2, 0), rgbpfc_pkg::SIZE_1B};
      default:    return '{24'hFF_FF_FF, pack_shifts(24, 16, 8), rgbpfc_pkg::SIZE_4B};
    endcase
  endfunction

  // Arbitrary layout: maxes mostly ragged, some all-ones fields, some zero
  function automatic fmt_t random_format();
    fmt_t f;
    for (int ch = 0; ch < rgbpfc_pkg::NUM_CH; ch++) begin
      case ($urandom_range(0, 5))
        0:       f.maxes[ch*CB +: CB] = '0;
        1, 2:    f.maxes[ch*CB +: CB] = CB'((1 << $urandom_range(1, CB)) - 1);
        default: f.maxes[ch*CB +: CB] = CB'($urandom);
      endcase
    end
    f.shifts = rgbpfc_pkg::SHIFTS_W'($urandom);
    f.size   = rgbpfc_pkg::SIZE_W'($urandom_range(0, 3));
    return f;
  endfunction

  function automatic fmt_t pick_format();
    if ($urandom_range(0, 2) != 0) return common_format($urandom_range(0, FMT_COUNT - 1));
    return random_format();
  endfunction

  // One register write beat, then valid low before returning; call at a rising edge
  task automatic write_reg(input logic [rgbpfc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      rgbpfc_pkg::CFG_SRC_MAXES:  src_max_r   = data;
      rgbpfc_pkg::CFG_SRC_SHIFTS: src_shift_r = data[rgbpfc_pkg::SHIFTS_W-1:0];
      rgbpfc_pkg::CFG_DST_MAXES:  dst_max_r   = data;
      rgbpfc_pkg::CFG_DST_SHIFTS: dst_shift_r = data[rgbpfc_pkg::SHIFTS_W-1:0];
      rgbpfc_pkg::CFG_SRC_SIZE:   src_size_r  = data[rgbpfc_pkg::SIZE_W-1:0];
      rgbpfc_pkg::CFG_DST_SIZE:   dst_size_r  = data[rgbpfc_pkg::SIZE_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_format(input fmt_t sf, input fmt_t df);
    write_reg(rgbpfc_pkg::CFG_SRC_MAXES, sf.maxes);
    write_reg(rgbpfc_pkg::CFG_SRC_SHIFTS, CFG_DATA_W'(sf.shifts));
    write_reg(rgbpfc_pkg::CFG_SRC_SIZE, CFG_DATA_W'(sf.size));
    write_reg(rgbpfc_pkg::CFG_DST_MAXES, df.maxes);
    write_reg(rgbpfc_pkg::CFG_DST_SHIFTS, CFG_DATA_W'(df.shifts));
    write_reg(rgbpfc_pkg::CFG_DST_SIZE, CFG_DATA_W'(df.size));
  endtask

  // Wait until every queued pixel went in and every conversion came out
  task automatic drain();
    while (source_fifo.size() != 0 || src_valid_i || converted_fifo.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Source side: a beat stays up until taken; random gaps between beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_valid_i    <= 1'b0;
      source_pixel_i <= '0;
      src_gap        <= 0;
    end else begin
      if (src_valid_i && !src_stall_o) begin
        converted_fifo.push_back('{source: source_pixel_i,
                                   target: convert_pixel(source_pixel_i)});
      end
      if (!src_valid_i || !src_stall_o) begin
        if (src_gap != 0) begin
          src_gap     <= src_gap - 1;
          src_valid_i <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          src_gap     <= $urandom_range(0, 4);
          src_valid_i <= 1'b0;
        end else if (source_fifo.size() != 0) begin
          src_valid_i    <= 1'b1;
          source_pixel_i <= source_fifo.pop_front();
        end else begin
          src_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result side: compare each beat with the oldest conversion, stall in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_stall_i <= 1'b0;
      dst_gap     <= 0;
    end else begin
      if (dst_valid_o && !dst_stall_i) begin
        if (converted_fifo.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("unexpected pixel out %h", target_pixel_o);
        end else begin
          head_beat = converted_fifo.pop_front();
          if (target_pixel_o !== head_beat.target) begin
            err_count++;
            if (err_count <= 10)
              $display("pixel mismatch: in %h out %h expected %h",
                       head_beat.source, target_pixel_o, head_beat.target);
          end
        end
      end
      if (dst_gap != 0) begin
        dst_gap     <= dst_gap - 1;
        dst_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        dst_gap     <= $urandom_range(0, 4);
        dst_stall_i <= 1'b1;
      end else begin
        dst_stall_i <= long_hold_on;
      end
    end
  end

  // Long receiver hold-off so the pipeline fills and backs up into the input
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    long_hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    long_hold_on <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    fmt_t sf;
    fmt_t df;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset layout: 24-bit identity with rounding
    source_fifo = {32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_0000, 32'h0000_FF00,
                   32'h0000_00FF, 32'h7F80_7F80, 32'h1234_5678};
    drain();

    // 32-bit down to 565
    set_format(common_format(FMT_RGB888), common_format(FMT_RGB565));
    source_fifo = {32'hFFFF_FFFF, 32'h0080_8080, 32'h0101_0101};
    drain();

    // 565 up to BGR: truncating source, upper half of the word ignored
    set_format(common_format(FMT_RGB565), common_format(FMT_BGR888));
    source_fifo = {32'hFFFF_0000, 32'h0000_FFFF, 32'h0000_F81F};
    drain();

    // 332 with green max zero; target shifts run past a 1-byte target
    sf = common_format(FMT_RGB332);
    sf.maxes[CB +: CB] = '0;
    df = '{24'hFF_FF_FF, pack_shifts(6, 3, 0), rgbpfc_pkg::SIZE_1B};
    set_format(sf, df);
    source_fifo = {32'h0000_00FF, 32'h0000_0000, 32'h0000_00A5, 32'hFFFF_FF5A};
    drain();

    // Spare size code, all-max shifts, oversize data, writes off the map
    write_reg(rgbpfc_pkg::CFG_SRC_MAXES, '1);
    write_reg(rgbpfc_pkg::CFG_SRC_SHIFTS, '1);
    write_reg(rgbpfc_pkg::CFG_SRC_SIZE, '1);
    write_reg(rgbpfc_pkg::CFG_DST_SIZE,
              {{(CFG_DATA_W-rgbpfc_pkg::SIZE_W){1'b1}}, SIZE_SPARE});
    write_reg(rgbpfc_pkg::CFG_DST_SHIFTS, '0);
    write_reg(rgbpfc_pkg::CFG_DST_MAXES, 24'h01_7F_FF);
    write_reg(CFG_NONE_A, '0);
    write_reg(CFG_NONE_B, '1);
    source_fifo = {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
    drain();

    // All source maxes zero
    write_reg(rgbpfc_pkg::CFG_SRC_MAXES, '0);
    source_fifo = {32'hFFFF_FFFF, 32'h1234_5678};
    drain();

    // Random layouts, mostly common formats
    for (int p = 0; p < RAND_PHASES; p++) begin
      sf = pick_format();
      df = pick_format();
      set_format(sf, df);
      quiet = (p == RAND_PHASES - 1);
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        case ($urandom_range(0, 9))
          0:       source_fifo.push_back('0);
          1:       source_fifo.push_back('1);
          default: source_fifo.push_back($urandom);
        endcase
      end
      if (p == 2) hold_go = 1'b1;
      drain();
    end

    if (err_count == 0 && converted_fifo.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
